// ===== src/kfsp_pkg.sv =====
package kfsp_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned HANDLE_W      = 16;
  localparam int unsigned CNT_OUT_W     = 7;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_COUNT  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_t;

  typedef struct packed {
    op_t                 opcode;
    logic [KEY_W-1:0]    entry_key;
    logic [HANDLE_W-1:0] record_handle;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]     out_key;
    logic [HANDLE_W-1:0]  out_record;
    logic [CNT_OUT_W-1:0] match_count;
    logic [CNT_OUT_W-1:0] occupancy;
    status_t              status;
  } result_t;

endpackage

// ===== src/kfsp_ram.sv =====
module kfsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/keyed_fifo_search_purge.sv =====
// channel   | direction | handshake                        | payload
// ----------+-----------+----------------------------------+----------------------------
// command   | in        | start high while busy low        | cmd (opcode, key, handle)
// result    | out       | done high for one cycle          | result (key, record, counts,
//           |           |                                  | status)
// config    | in        | cfg_valid and cfg_ready          | cfg_data (capacity limit)
//
// cycles: enqueue, a refused enqueue and any request on an empty queue give their
// result in the cycle after acceptance; dequeue passes through S_DEQ (one ring memory read);
// count and remove walk every stored entry in S_SCAN, since the single read port
// of the ring memory delivers one entry per cycle during the walk.
// busy is high while a dequeue, count or remove is in S_DEQ or S_SCAN, and low again
// in the cycle done rises; a new request may be accepted in the same cycle as done.
// reset: rst is synchronous; it empties the queue and sets the capacity limit to 64.
// the store contents are not cleared, an empty queue never reads them.
// stalls: the receiver cannot stall, each result is shown exactly once.
module keyed_fifo_search_purge
  import kfsp_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  // result channel
  output logic             done,
  output result_t          result,
  // capacity limit register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned RAM_W = KEY_W + HANDLE_W;

  // ring successor, wraps at the store depth (need not be a power of two)
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    return r;
  endfunction

  // control state
  state_t             state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CAP_W-1:0]   capacity;
  logic               done_next;

  // scan bookkeeping for count and remove
  logic [IDX_W-1:0]   rd_ptr, rd_ptr_next;   // next entry to read
  logic [IDX_W-1:0]   wr_ptr, wr_ptr_next;   // next slot for a survivor
  logic [CNT_W-1:0]   issued, issued_next;   // reads launched so far
  logic [CNT_W-1:0]   kept, kept_next;       // survivors written back
  logic [CNT_W-1:0]   match_cnt, match_cnt_next;
  logic [KEY_W-1:0]   key_q, key_q_next;
  logic               is_remove, is_remove_next;
  result_t            result_next;

  // ring memory port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [RAM_W-1:0]   ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [HANDLE_W-1:0] rd_handle;

  // scan step terms
  logic               accept;
  logic               full;
  logic [LIM_W-1:0]   limit;
  logic               issue;
  logic               hit;
  logic               keep;
  logic [CNT_W-1:0]   match_cnt_sum;
  logic [CNT_W-1:0]   kept_sum;
  logic [IDX_W-1:0]   wr_ptr_sum;

  kfsp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key    = ram_rdata[RAM_W-1 -: KEY_W];
  assign rd_handle = ram_rdata[HANDLE_W-1:0];

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  // user must write config only while idle; not enforced, so the register is always open
  assign cfg_ready = 1'b1;

  // limit in force saturates at the store depth
  always_comb begin
    if (LIM_W'(capacity) > LIM_W'(DEPTH)) begin
      limit = LIM_W'(DEPTH);
    end else begin
      limit = LIM_W'(capacity);
    end
  end
  assign full = (LIM_W'(count) >= limit);

  // one scan step: the read launched last cycle is on ram_rdata now
  assign issue         = (issued != count);
  assign hit           = (rd_key == key_q);
  assign keep          = is_remove && !hit;
  assign match_cnt_sum = match_cnt + CNT_W'(hit);
  assign kept_sum      = kept + CNT_W'(keep);
  assign wr_ptr_sum    = keep ? ring_next(wr_ptr) : wr_ptr;

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    issued_next    = issued;
    kept_next      = kept;
    match_cnt_next = match_cnt;
    key_q_next     = key_q;
    is_remove_next = is_remove;
    result_next    = result;
    done_next      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = {cmd.entry_key, cmd.record_handle};
    ram_raddr      = head;

    unique case (state)
      S_IDLE: begin
        // head is on the read address so dequeue and scan start at once
        if (accept) begin
          result_next.out_key     = '0;
          result_next.out_record  = '0;
          result_next.match_count = '0;
          result_next.occupancy   = CNT_OUT_W'(count);
          result_next.status      = ST_OK;
          if (cmd.opcode == OP_ENQ) begin
            done_next = 1'b1;
            if (full) begin
              result_next.status = ST_FULL;
            end else begin
              ram_we                = 1'b1;
              tail_next             = ring_next(tail);
              count_next            = count + 1'b1;
              result_next.occupancy = CNT_OUT_W'(count + 1'b1);
            end
          end else if (count == '0) begin
            done_next          = 1'b1;
            result_next.status = ST_EMPTY;
          end else if (cmd.opcode == OP_DEQ) begin
            state_next = S_DEQ;
          end else begin
            // walk from head; the first read is already launched
            state_next     = S_SCAN;
            rd_ptr_next    = ring_next(head);
            issued_next    = CNT_W'(1);
            wr_ptr_next    = head;
            kept_next      = '0;
            match_cnt_next = '0;
            key_q_next     = cmd.entry_key;
            is_remove_next = (cmd.opcode == OP_REMOVE);
          end
        end
      end

      S_DEQ: begin
        result_next.out_key     = rd_key;
        result_next.out_record  = rd_handle;
        result_next.match_count = '0;
        result_next.occupancy   = CNT_OUT_W'(count - 1'b1);
        result_next.status      = ST_OK;
        head_next               = ring_next(head);
        count_next              = count - 1'b1;
        done_next               = 1'b1;
        state_next              = S_IDLE;
      end

      S_SCAN: begin
        ram_raddr = rd_ptr;
        if (issue) begin
          rd_ptr_next = ring_next(rd_ptr);
          issued_next = issued + 1'b1;
        end
        // survivors pack down behind the read pointer, never ahead of it
        if (keep) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr;
          ram_wdata = ram_rdata;
        end
        wr_ptr_next    = wr_ptr_sum;
        kept_next      = kept_sum;
        match_cnt_next = match_cnt_sum;
        if (!issue) begin
          // last entry is in hand: finish
          done_next               = 1'b1;
          state_next              = S_IDLE;
          result_next.out_key     = '0;
          result_next.out_record  = '0;
          result_next.match_count = CNT_OUT_W'(match_cnt_sum);
          result_next.occupancy   = CNT_OUT_W'(count);
          result_next.status      = ST_OK;
          if (match_cnt_sum == '0) begin
            result_next.status = ST_NOTFOUND;
          end else if (is_remove) begin
            count_next            = kept_sum;
            tail_next             = wr_ptr_sum;
            result_next.occupancy = CNT_OUT_W'(kept_sum);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // queue pointers, result strobe and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      done     <= 1'b0;
      capacity <= CAP_RESET;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  // scan working registers and result payload
  always_ff @(posedge clk) begin
    rd_ptr    <= rd_ptr_next;
    wr_ptr    <= wr_ptr_next;
    issued    <= issued_next;
    kept      <= kept_next;
    match_cnt <= match_cnt_next;
    key_q     <= key_q_next;
    is_remove <= is_remove_next;
    result    <= result_next;
  end

`ifndef NO_ASSERTIONS
  // a result only follows an accepted request or the end of a multi-cycle one
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept || state == S_DEQ || state == S_SCAN))
    else $error("result strobe without a request in flight");

  // an enqueue at the limit is refused in the very next cycle
  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_ENQ && full) |=> (done && result.status == ST_FULL
      && count == $past(count)))
    else $error("enqueue at limit not refused");

  // compaction never writes more survivors than entries held
  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (kept < count && issued <= count && count != '0))
    else $error("scan counters out of range");

  // occupancy never exceeds the store depth
  a_count_depth: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count <= CNT_W'(DEPTH)))
    else $error("occupancy beyond store depth");
`endif

endmodule
